// File: rtl/core/atapio_pkg.sv
// Shared types and constants for the ATA PIO sector sequencer.
package atapio_pkg;

  localparam int BLOCK_BYTES    = 512;
  localparam int IDENTIFY_WORDS = 62;
  localparam int QUEUE_DEPTH    = 4;

  localparam int WC_W = 16;
  localparam logic [WC_W-1:0] BLOCK_WORDS = WC_W'((BLOCK_BYTES + 1) / 2);
  localparam logic [WC_W-1:0] ID_WORDS    = WC_W'(IDENTIFY_WORDS);

  // input request types
  localparam logic [1:0] REQ_HOST_CMD  = 2'd0;
  localparam logic [1:0] REQ_DRV_RESP  = 2'd1;
  localparam logic [1:0] REQ_HOST_WORD = 2'd2;

  // host commands
  localparam logic [1:0] CMD_IDENTIFY = 2'd0;
  localparam logic [1:0] CMD_READ     = 2'd1;
  localparam logic [1:0] CMD_WRITE    = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_BUS_RD = 2'd0;
  localparam logic [1:0] KIND_BUS_WR = 2'd1;
  localparam logic [1:0] KIND_HOST   = 2'd2;
  localparam logic [1:0] KIND_DONE   = 2'd3;

  // task-file registers
  localparam logic [2:0] REG_DATA   = 3'd0;
  localparam logic [2:0] REG_COUNT  = 3'd2;
  localparam logic [2:0] REG_LBA0   = 3'd3;
  localparam logic [2:0] REG_LBA1   = 3'd4;
  localparam logic [2:0] REG_LBA2   = 3'd5;
  localparam logic [2:0] REG_DEVICE = 3'd6;
  localparam logic [2:0] REG_CMD    = 3'd7;

  // drive constants
  localparam logic [15:0] DEV_CHS     = 16'h00A0;
  localparam logic [3:0]  DEV_LBA_HI  = 4'hE;
  localparam logic [15:0] ATA_IDENT   = 16'h00EC;
  localparam logic [15:0] ATA_RD_SECT = 16'h0021;
  localparam logic [15:0] ATA_WR_SECT = 16'h0031;
  localparam int ST_BSY_BIT  = 7;
  localparam int ST_DRDY_BIT = 6;
  localparam int ST_DRQ_BIT  = 3;
  localparam int ID_LBA_BIT  = 9;
  localparam logic [WC_W-1:0] ID_W_CAPS = WC_W'(49);
  localparam logic [WC_W-1:0] ID_W_SZLO = WC_W'(60);
  localparam logic [WC_W-1:0] ID_W_SZHI = WC_W'(61);

  // jobs handed from front to back
  typedef logic [3:0] job_op_t;
  localparam job_op_t JOB_ID_START = 4'd0;  // wr device A0, poll
  localparam job_op_t JOB_POLL     = 4'd1;  // poll status
  localparam job_op_t JOB_ID_CMD   = 4'd2;  // wr identify cmd, poll
  localparam job_op_t JOB_RD_DATA  = 4'd3;  // read data reg
  localparam job_op_t JOB_ID_DONE  = 4'd4;  // identify done
  localparam job_op_t JOB_SETUP    = 4'd5;  // task file + cmd, poll
  localparam job_op_t JOB_HW_NEXT  = 4'd6;  // host word, read data reg
  localparam job_op_t JOB_HW_DONE  = 4'd7;  // host word, done
  localparam job_op_t JOB_WR       = 4'd8;  // wr data reg
  localparam job_op_t JOB_WR_DONE  = 4'd9;  // wr data reg, done

  typedef struct packed {
    job_op_t     op;
    logic [15:0] word;
    logic [27:0] lba;
    logic        is_write;
    logic        lba_flag;
    logic [31:0] size;
  } job_t;

endpackage

// File: rtl/core/atapio_front.sv
// Front end: accepts items, tracks the protocol phase and issues jobs.
module atapio_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_req_type,
  input  logic [1:0]         in_command,
  input  logic [27:0]        in_block_number,
  input  logic [15:0]        in_bus_data,
  input  logic [15:0]        in_host_word,
  input  logic               q_full,
  output logic               q_push,
  output atapio_pkg::job_t   q_job
);
  import atapio_pkg::*;

  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_ID_DRDY = 4'd1;
  localparam logic [3:0] PH_ID_BSY  = 4'd2;
  localparam logic [3:0] PH_ID_DRQ  = 4'd3;
  localparam logic [3:0] PH_ID_DATA = 4'd4;
  localparam logic [3:0] PH_SET_BSY = 4'd5;
  localparam logic [3:0] PH_XF_DRQ  = 4'd6;
  localparam logic [3:0] PH_XF_BSY  = 4'd7;
  localparam logic [3:0] PH_RD_DATA = 4'd8;
  localparam logic [3:0] PH_WR_DATA = 4'd9;

  logic [3:0]      phase_r, phase_nxt;
  logic [1:0]      op_kind_r, op_kind_nxt;
  logic [27:0]     lba_r, lba_nxt;
  logic [WC_W-1:0] wc_r, wc_nxt;
  logic            lba_flag_r, lba_flag_nxt;
  logic [31:0]     total_r, total_nxt;

  logic            accept;
  logic [WC_W-1:0] wc_inc;
  logic [7:0]      st;

  assign accept = in_valid && !q_full;
  assign wc_inc = wc_r + WC_W'(1);
  assign st     = in_bus_data[7:0];

  always_comb begin
    phase_nxt    = phase_r;
    op_kind_nxt  = op_kind_r;
    lba_nxt      = lba_r;
    wc_nxt       = wc_r;
    lba_flag_nxt = lba_flag_r;
    total_nxt    = total_r;
    q_push       = 1'b0;
    q_job        = '0;
    q_job.word   = in_host_word;
    if (accept) begin
      case (in_req_type)
        REQ_HOST_CMD: begin
          if (phase_r == PH_IDLE && in_command == CMD_IDENTIFY) begin
            op_kind_nxt  = CMD_IDENTIFY;
            lba_flag_nxt = 1'b0;
            q_push       = 1'b1;
            q_job.op     = JOB_ID_START;
            phase_nxt    = PH_ID_DRDY;
          end else if (phase_r == PH_IDLE &&
                       (in_command == CMD_READ || in_command == CMD_WRITE)) begin
            op_kind_nxt = in_command;
            lba_nxt     = in_block_number;
            q_push      = 1'b1;
            q_job.op    = JOB_POLL;
            phase_nxt   = PH_SET_BSY;
          end
        end
        REQ_DRV_RESP: begin
          case (phase_r)
            PH_ID_DRDY: begin
              q_push   = 1'b1;
              q_job.op = JOB_POLL;
              if (st[ST_DRDY_BIT]) phase_nxt = PH_ID_BSY;
            end
            PH_ID_BSY: begin
              q_push = 1'b1;
              if (st[ST_BSY_BIT]) begin
                q_job.op = JOB_POLL;
              end else begin
                q_job.op  = JOB_ID_CMD;
                phase_nxt = PH_ID_DRQ;
              end
            end
            PH_ID_DRQ: begin
              q_push = 1'b1;
              if (!st[ST_DRQ_BIT]) begin
                q_job.op = JOB_POLL;
              end else begin
                wc_nxt    = '0;
                q_job.op  = JOB_RD_DATA;
                phase_nxt = PH_ID_DATA;
              end
            end
            PH_ID_DATA: begin
              if (wc_r == ID_W_CAPS) begin
                lba_flag_nxt = in_bus_data[ID_LBA_BIT];
              end else if (wc_r == ID_W_SZLO) begin
                total_nxt = {total_r[31:16], in_bus_data};
              end else if (wc_r == ID_W_SZHI) begin
                total_nxt = {in_bus_data, total_r[15:0]};
              end
              wc_nxt = wc_inc;
              q_push = 1'b1;
              if (wc_inc < ID_WORDS) begin
                q_job.op = JOB_RD_DATA;
              end else begin
                q_job.op       = JOB_ID_DONE;
                q_job.lba_flag = lba_flag_nxt;
                q_job.size     = total_nxt;
                phase_nxt      = PH_IDLE;
              end
            end
            PH_SET_BSY: begin
              q_push = 1'b1;
              if (st[ST_BSY_BIT]) begin
                q_job.op = JOB_POLL;
              end else begin
                q_job.op       = JOB_SETUP;
                q_job.lba      = lba_r;
                q_job.is_write = (op_kind_r == CMD_WRITE);
                phase_nxt      = PH_XF_DRQ;
              end
            end
            PH_XF_DRQ: begin
              q_push   = 1'b1;
              q_job.op = JOB_POLL;
              if (st[ST_DRQ_BIT]) phase_nxt = PH_XF_BSY;
            end
            PH_XF_BSY: begin
              if (st[ST_BSY_BIT]) begin
                q_push   = 1'b1;
                q_job.op = JOB_POLL;
              end else begin
                wc_nxt = '0;
                if (op_kind_r == CMD_WRITE) begin
                  phase_nxt = PH_WR_DATA;
                end else begin
                  q_push    = 1'b1;
                  q_job.op  = JOB_RD_DATA;
                  phase_nxt = PH_RD_DATA;
                end
              end
            end
            PH_RD_DATA: begin
              wc_nxt     = wc_inc;
              q_push     = 1'b1;
              q_job.word = in_bus_data;
              if (wc_inc < BLOCK_WORDS) begin
                q_job.op = JOB_HW_NEXT;
              end else begin
                q_job.op  = JOB_HW_DONE;
                phase_nxt = PH_IDLE;
              end
            end
            default: begin
            end
          endcase
        end
        REQ_HOST_WORD: begin
          if (phase_r == PH_WR_DATA) begin
            wc_nxt = wc_inc;
            q_push = 1'b1;
            if (wc_inc >= BLOCK_WORDS) begin
              q_job.op  = JOB_WR_DONE;
              phase_nxt = PH_IDLE;
            end else begin
              q_job.op = JOB_WR;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      op_kind_r  <= '0;
      lba_r      <= '0;
      wc_r       <= '0;
      lba_flag_r <= 1'b0;
      total_r    <= '0;
    end else begin
      phase_r    <= phase_nxt;
      op_kind_r  <= op_kind_nxt;
      lba_r      <= lba_nxt;
      wc_r       <= wc_nxt;
      lba_flag_r <= lba_flag_nxt;
      total_r    <= total_nxt;
    end
  end

endmodule

// File: rtl/core/atapio_queue.sv
// Job queue between front and back ends.
module atapio_queue #(
  parameter int DEPTH = atapio_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  atapio_pkg::job_t   push_job,
  input  logic               pop,
  output atapio_pkg::job_t   head_job,
  output logic               full,
  output logic               empty
);
  import atapio_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  job_t             mem [DEPTH];
  job_t             head_r;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CNT_FULL);
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = head_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    if (do_push && !do_pop) cnt_nxt = cnt_r + CNT_W'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_job;
  end

  // head register tracks the entry at the next read pointer, with write bypass
  always_ff @(posedge clk) begin
    if (do_push && wr_ptr_r == rd_ptr_nxt) head_r <= push_job;
    else head_r <= mem[rd_ptr_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// File: rtl/core/atapio_back.sv
// Back end: expands each job into result items, one per cycle while out_stall is low.
module atapio_back (
  input  logic               clk,
  input  logic               rst_n,
  input  atapio_pkg::job_t   head_job,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_result_kind,
  output logic [2:0]         out_reg_index,
  output logic [15:0]        out_bus_word,
  output logic [15:0]        out_host_word_out,
  output logic               out_lba_supported,
  output logic [31:0]        out_disk_size,
  output logic               out_last
);
  import atapio_pkg::*;

  logic [2:0]  step_r, step_nxt;
  logic        out_valid_r;
  logic [1:0]  kind_r, kind_c;
  logic [2:0]  reg_r, reg_c;
  logic [15:0] bw_r, bw_c;
  logic [15:0] hw_r, hw_c;
  logic        lf_r, lf_c;
  logic [31:0] ds_r, ds_c;
  logic        last_r, last_c;
  logic        load;

  assign load = !q_empty && (!out_valid_r || !out_stall);

  always_comb begin
    kind_c = KIND_BUS_RD;
    reg_c  = REG_CMD;
    bw_c   = '0;
    hw_c   = '0;
    lf_c   = 1'b0;
    ds_c   = '0;
    last_c = 1'b1;
    case (head_job.op)
      JOB_ID_START: begin
        last_c = (step_r == 3'd1);
        if (step_r == 3'd0) begin
          kind_c = KIND_BUS_WR;
          reg_c  = REG_DEVICE;
          bw_c   = DEV_CHS;
        end
      end
      JOB_POLL: begin
      end
      JOB_ID_CMD: begin
        last_c = (step_r == 3'd1);
        if (step_r == 3'd0) begin
          kind_c = KIND_BUS_WR;
          bw_c   = ATA_IDENT;
        end
      end
      JOB_RD_DATA: begin
        reg_c = REG_DATA;
      end
      JOB_ID_DONE: begin
        kind_c = KIND_DONE;
        reg_c  = REG_DATA;
        lf_c   = head_job.lba_flag;
        ds_c   = head_job.size;
      end
      JOB_SETUP: begin
        last_c = (step_r == 3'd6);
        kind_c = KIND_BUS_WR;
        case (step_r)
          3'd0: begin reg_c = REG_COUNT;  bw_c = 16'd1; end
          3'd1: begin reg_c = REG_LBA0;   bw_c = {8'd0, head_job.lba[7:0]}; end
          3'd2: begin reg_c = REG_LBA1;   bw_c = {8'd0, head_job.lba[15:8]}; end
          3'd3: begin reg_c = REG_LBA2;   bw_c = {8'd0, head_job.lba[23:16]}; end
          3'd4: begin
            reg_c = REG_DEVICE;
            bw_c  = {8'd0, DEV_LBA_HI, head_job.lba[27:24]};
          end
          3'd5: begin
            reg_c = REG_CMD;
            bw_c  = head_job.is_write ? ATA_WR_SECT : ATA_RD_SECT;
          end
          default: begin
            kind_c = KIND_BUS_RD;
            reg_c  = REG_CMD;
          end
        endcase
      end
      JOB_HW_NEXT: begin
        last_c = (step_r == 3'd1);
        reg_c  = REG_DATA;
        if (step_r == 3'd0) begin
          kind_c = KIND_HOST;
          hw_c   = head_job.word;
        end
      end
      JOB_HW_DONE: begin
        last_c = (step_r == 3'd1);
        reg_c  = REG_DATA;
        if (step_r == 3'd0) begin
          kind_c = KIND_HOST;
          hw_c   = head_job.word;
        end else begin
          kind_c = KIND_DONE;
        end
      end
      JOB_WR: begin
        kind_c = KIND_BUS_WR;
        reg_c  = REG_DATA;
        bw_c   = head_job.word;
      end
      JOB_WR_DONE: begin
        last_c = (step_r == 3'd1);
        reg_c  = REG_DATA;
        if (step_r == 3'd0) begin
          kind_c = KIND_BUS_WR;
          bw_c   = head_job.word;
        end else begin
          kind_c = KIND_DONE;
        end
      end
      default: begin
        kind_c = KIND_DONE;
        reg_c  = REG_DATA;
      end
    endcase
  end

  assign q_pop    = load && last_c;
  assign step_nxt = load ? (last_c ? 3'd0 : step_r + 3'd1) : step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= kind_c;
      reg_r  <= reg_c;
      bw_r   <= bw_c;
      hw_r   <= hw_c;
      lf_r   <= lf_c;
      ds_r   <= ds_c;
      last_r <= last_c;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_kind   = kind_r;
  assign out_reg_index     = reg_r;
  assign out_bus_word      = bw_r;
  assign out_host_word_out = hw_r;
  assign out_lba_supported = lf_r;
  assign out_disk_size     = ds_r;
  assign out_last          = last_r;

endmodule

// File: rtl/core/ata_pio_sector_sequencer.sv
// Top level of the ATA PIO LBA28 sector sequencer.
//
//   channel | direction | handshake          | carries
//   in_     | input     | in_valid/in_stall   | host command, drive response or host word
//   out_    | output    | out_valid/out_stall | bus access, host word or done
//
// The front end takes one item per cycle while in_stall is low and turns it
// into at most one job. The back end emits one result per cycle while
// out_stall is low; a job yields 1 to 7 results (setup: 7).
// A QUEUE_DEPTH job queue separates them; in_stall rises only when it is full.
// rst_n is synchronous; it clears phase, counters, queue and output valid.
// out_stall holds the output register; the queue keeps filling behind it.
module ata_pio_sector_sequencer #(
  parameter int QUEUE_DEPTH = atapio_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [1:0]  in_command,
  input  logic [27:0] in_block_number,
  input  logic [15:0] in_bus_data,
  input  logic [15:0] in_host_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [2:0]  out_reg_index,
  output logic [15:0] out_bus_word,
  output logic [15:0] out_host_word_out,
  output logic        out_lba_supported,
  output logic [31:0] out_disk_size,
  output logic        out_last
);
  import atapio_pkg::*;

  job_t push_job, head_job;
  logic q_push, q_pop, q_full, q_empty;

  assign in_stall = q_full;

  atapio_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_req_type     (in_req_type),
    .in_command      (in_command),
    .in_block_number (in_block_number),
    .in_bus_data     (in_bus_data),
    .in_host_word    (in_host_word),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_job           (push_job)
  );

  atapio_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  atapio_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_job          (head_job),
    .q_empty           (q_empty),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_kind   (out_result_kind),
    .out_reg_index     (out_reg_index),
    .out_bus_word      (out_bus_word),
    .out_host_word_out (out_host_word_out),
    .out_lba_supported (out_lba_supported),
    .out_disk_size     (out_disk_size),
    .out_last          (out_last)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("job pushed into full queue");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind == KIND_DONE) |-> out_last)
    else $error("done item not marked last");

  a_reg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_result_kind == KIND_HOST || out_result_kind == KIND_DONE))
      |-> (out_reg_index == REG_DATA))
    else $error("register index set on host or done item");

  a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (out_valid && out_last))
    else $error("job retired without a last item");

endmodule

// File: bench/testbench.sv
// Self-checking testbench for the ATA PIO sector sequencer: predicted bus accesses vs. outputs.
`timescale 1ns / 100ps

module testbench;
  import atapio_pkg::*;

  typedef enum logic [3:0] {
    SEQ_IDLE, SEQ_ID_DRDY, SEQ_ID_BSY, SEQ_ID_DRQ, SEQ_ID_DATA,
    SEQ_WAIT_BSY, SEQ_XF_DRQ, SEQ_XF_BSY, SEQ_RD_DATA, SEQ_WR_DATA
  } seq_phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  reg_idx;
    logic [15:0] bus_word;
    logic [15:0] host_word;
    logic        lba_sup;
    logic [31:0] disk_size;
    logic        last;
  } access_t;

  class access_scoreboard;
    seq_phase_t  phase;
    logic [1:0]  op;
    logic [27:0] lba_q;
    logic [15:0] words;
    logic        lba_flag;
    logic [31:0] sectors;
    access_t     burst[$];
    access_t     pending[$];
    int          errors;
    int          ident_done;
    int          read_done;
    int          write_done;

    function new();
      phase = SEQ_IDLE;
      op = CMD_IDENTIFY;
      lba_q = '0;
      words = '0;
      lba_flag = 1'b0;
      sectors = '0;
      errors = 0;
      ident_done = 0;
      read_done = 0;
      write_done = 0;
    endfunction

    function void add(logic [1:0] kind, logic [2:0] reg_idx, logic [15:0] bw,
                      logic [15:0] hw, logic lf, logic [31:0] ds);
      access_t a;
      a.kind = kind;
      a.reg_idx = reg_idx;
      a.bus_word = bw;
      a.host_word = hw;
      a.lba_sup = lf;
      a.disk_size = ds;
      a.last = 1'b0;
      burst.push_back(a);
    endfunction

    function int note_item(logic [1:0] req, logic [1:0] cmd, logic [27:0] lba,
                           logic [15:0] data, logic [15:0] hword);
      logic [7:0] status;
      status = data[7:0];
      burst.delete();
      if (req == REQ_HOST_CMD) begin
        if (phase == SEQ_IDLE && cmd == CMD_IDENTIFY) begin
          op = CMD_IDENTIFY;
          lba_flag = 1'b0;
          add(KIND_BUS_WR, REG_DEVICE, DEV_CHS, '0, 1'b0, '0);
          add(KIND_BUS_RD, REG_CMD, '0, '0, 1'b0, '0);
          phase = SEQ_ID_DRDY;
        end else if (phase == SEQ_IDLE && (cmd == CMD_READ || cmd == CMD_WRITE)) begin
          op = cmd;
          lba_q = lba;
          add(KIND_BUS_RD, REG_CMD, '0, '0, 1'b0, '0);
          phase = SEQ_WAIT_BSY;
        end
      end else if (req == REQ_DRV_RESP) begin
        case (phase)
          SEQ_ID_DRDY: begin
            add(KIND_BUS_RD, REG_CMD, '0, '0, 1'b0, '0);
            if (status[ST_DRDY_BIT]) phase = SEQ_ID_BSY;
          end
          SEQ_ID_BSY: begin
            if (status[ST_BSY_BIT]) begin
              add(KIND_BUS_RD, REG_CMD, '0, '0, 1'b0, '0);
            end else begin
              add(KIND_BUS_WR, REG_CMD, ATA_IDENT, '0, 1'b0, '0);
              add(KIND_BUS_RD, REG_CMD, '0, '0, 1'b0, '0);
              phase = SEQ_ID_DRQ;
            end
          end
          SEQ_ID_DRQ: begin
            if (!status[ST_DRQ_BIT]) begin
              add(KIND_BUS_RD, REG_CMD, '0, '0, 1'b0, '0);
            end else begin
              words = '0;
              add(KIND_BUS_RD, REG_DATA, '0, '0, 1'b0, '0);
              phase = SEQ_ID_DATA;
            end
          end
          SEQ_ID_DATA: begin
            if (words == ID_W_CAPS) lba_flag = data[ID_LBA_BIT];
            else if (words == ID_W_SZLO) sectors[15:0] = data;
            else if (words == ID_W_SZHI) sectors[31:16] = data;
            words = words + 1'b1;
            if (words < ID_WORDS) begin
              add(KIND_BUS_RD, REG_DATA, '0, '0, 1'b0, '0);
            end else begin
              add(KIND_DONE, REG_DATA, '0, '0, lba_flag, sectors);
              phase = SEQ_IDLE;
              ident_done++;
            end
          end
          SEQ_WAIT_BSY: begin
            if (status[ST_BSY_BIT]) begin
              add(KIND_BUS_RD, REG_CMD, '0, '0, 1'b0, '0);
            end else begin
              add(KIND_BUS_WR, REG_COUNT, 16'd1, '0, 1'b0, '0);
              add(KIND_BUS_WR, REG_LBA0, {8'h00, lba_q[7:0]}, '0, 1'b0, '0);
              add(KIND_BUS_WR, REG_LBA1, {8'h00, lba_q[15:8]}, '0, 1'b0, '0);
              add(KIND_BUS_WR, REG_LBA2, {8'h00, lba_q[23:16]}, '0, 1'b0, '0);
              add(KIND_BUS_WR, REG_DEVICE, {8'h00, DEV_LBA_HI, lba_q[27:24]}, '0, 1'b0, '0);
              add(KIND_BUS_WR, REG_CMD, (op == CMD_WRITE) ? ATA_WR_SECT : ATA_RD_SECT,
                  '0, 1'b0, '0);
              add(KIND_BUS_RD, REG_CMD, '0, '0, 1'b0, '0);
              phase = SEQ_XF_DRQ;
            end
          end
          SEQ_XF_DRQ: begin
            add(KIND_BUS_RD, REG_CMD, '0, '0, 1'b0, '0);
            if (status[ST_DRQ_BIT]) phase = SEQ_XF_BSY;
          end
          SEQ_XF_BSY: begin
            if (status[ST_BSY_BIT]) begin
              add(KIND_BUS_RD, REG_CMD, '0, '0, 1'b0, '0);
            end else begin
              words = '0;
              if (op == CMD_WRITE) begin
                phase = SEQ_WR_DATA;
              end else begin
                add(KIND_BUS_RD, REG_DATA, '0, '0, 1'b0, '0);
                phase = SEQ_RD_DATA;
              end
            end
          end
          SEQ_RD_DATA: begin
            add(KIND_HOST, REG_DATA, '0, data, 1'b0, '0);
            words = words + 1'b1;
            if (words < BLOCK_WORDS) begin
              add(KIND_BUS_RD, REG_DATA, '0, '0, 1'b0, '0);
            end else begin
              add(KIND_DONE, REG_DATA, '0, '0, 1'b0, '0);
              phase = SEQ_IDLE;
              read_done++;
            end
          end
          default: ;
        endcase
      end else if (req == REQ_HOST_WORD && phase == SEQ_WR_DATA) begin
        add(KIND_BUS_WR, REG_DATA, hword, '0, 1'b0, '0);
        words = words + 1'b1;
        if (words >= BLOCK_WORDS) begin
          add(KIND_DONE, REG_DATA, '0, '0, 1'b0, '0);
          phase = SEQ_IDLE;
          write_done++;
        end
      end
      if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
      foreach (burst[i]) pending.push_back(burst[i]);
      return burst.size();
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      errors++;
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %0h, expected %0h", name, got, want));
    endtask

    task check_result(access_t got);
      access_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result, kind %0d", got.kind));
      end else begin
        want = pending.pop_front();
        compare_field("result_kind", got.kind, want.kind);
        compare_field("reg_index", got.reg_idx, want.reg_idx);
        compare_field("bus_word", got.bus_word, want.bus_word);
        compare_field("host_word_out", got.host_word, want.host_word);
        compare_field("lba_supported", got.lba_sup, want.lba_sup);
        compare_field("disk_size", got.disk_size, want.disk_size);
        compare_field("last", got.last, want.last);
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_req_type = '0;
  logic [1:0]  in_command = '0;
  logic [27:0] in_block_number = '0;
  logic [15:0] in_bus_data = '0;
  logic [15:0] in_host_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_result_kind;
  logic [2:0]  out_reg_index;
  logic [15:0] out_bus_word;
  logic [15:0] out_host_word_out;
  logic        out_lba_supported;
  logic [31:0] out_disk_size;
  logic        out_last;

  access_scoreboard sb;
  bit in_idle = 1'b0;
  bit out_idle = 1'b0;
  int out_hold = 0;
  int step_count = 0;

  ata_pio_sector_sequencer i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_command        (in_command),
    .in_block_number   (in_block_number),
    .in_bus_data       (in_bus_data),
    .in_host_word      (in_host_word),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_kind   (out_result_kind),
    .out_reg_index     (out_reg_index),
    .out_bus_word      (out_bus_word),
    .out_host_word_out (out_host_word_out),
    .out_lba_supported (out_lba_supported),
    .out_disk_size     (out_disk_size),
    .out_last          (out_last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(access_t'({out_result_kind, out_reg_index, out_bus_word,
                                 out_host_word_out, out_lba_supported, out_disk_size,
                                 out_last}));
      out_hold = out_idle ? $urandom_range(0, 3) : 0;
    end else if (out_hold > 0) begin
      out_hold--;
    end
    out_stall <= (out_hold > 0);
  end

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [27:0] pick_lba();
    case ($urandom_range(0, 3))
      0: return 28'h0000000;
      1: return 28'hFFFFFFF;
      default: return 28'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] status_word(int bit_pos, logic level);
    logic [15:0] w;
    w = 16'($urandom);
    w[bit_pos] = level;
    return w;
  endfunction

  task automatic drive_item(logic [1:0] req, logic [1:0] cmd, logic [27:0] lba,
                            logic [15:0] data, logic [15:0] hword);
    int gap;
    gap = in_idle ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_command <= cmd;
    in_block_number <= lba;
    in_bus_data <= data;
    in_host_word <= hword;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    void'(sb.note_item(req, cmd, lba, data, hword));
  endtask

  task automatic next_step();
    logic [1:0]  req;
    logic [1:0]  cmd;
    logic [27:0] lba;
    logic [15:0] data;
    logic [15:0] hword;
    logic        coin;
    req = REQ_DRV_RESP;
    cmd = 2'($urandom);
    lba = pick_lba();
    data = pick_word();
    hword = pick_word();
    coin = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 9) == 0) begin
      req = 2'($urandom);
    end else begin
      case (sb.phase)
        SEQ_IDLE: begin
          req = REQ_HOST_CMD;
          if (sb.ident_done == 0) cmd = CMD_IDENTIFY;
          else if (sb.read_done == 0 && sb.write_done == 0)
            cmd = coin ? CMD_READ : CMD_WRITE;
          else cmd = 2'($urandom_range(0, 2));
        end
        SEQ_ID_DRDY: data = status_word(ST_DRDY_BIT, coin);
        SEQ_ID_BSY, SEQ_WAIT_BSY, SEQ_XF_BSY: data = status_word(ST_BSY_BIT, coin);
        SEQ_ID_DRQ, SEQ_XF_DRQ: data = status_word(ST_DRQ_BIT, coin);
        SEQ_WR_DATA: req = REQ_HOST_WORD;
        default: ;
      endcase
    end
    drive_item(req, cmd, lba, data, hword);
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // stray items at idle
    drive_item(2'd3, 2'd3, '1, '1, '1);
    drive_item(REQ_DRV_RESP, CMD_READ, '1, 16'h00FF, '1);
    drive_item(REQ_HOST_WORD, CMD_WRITE, '0, '0, 16'hFFFF);
    drive_item(REQ_HOST_CMD, 2'd3, '1, '1, '1);
    // identify opening: every poll branch, strays while busy
    drive_item(REQ_HOST_CMD, CMD_IDENTIFY, '1, '0, '0);
    drive_item(REQ_DRV_RESP, CMD_IDENTIFY, '0, 16'h00BF, '0);
    drive_item(REQ_DRV_RESP, CMD_IDENTIFY, '0, 16'hFF40, '0);
    drive_item(REQ_DRV_RESP, CMD_IDENTIFY, '0, 16'h0080, '0);
    drive_item(REQ_HOST_CMD, CMD_READ, '1, '0, '0);
    drive_item(REQ_HOST_WORD, CMD_IDENTIFY, '0, '0, 16'hFFFF);
    drive_item(REQ_DRV_RESP, CMD_IDENTIFY, '0, 16'hFF7F, '0);
    drive_item(REQ_DRV_RESP, CMD_IDENTIFY, '0, 16'h00F7, '0);
    drive_item(2'd3, CMD_WRITE, '1, 16'h0008, '1);
    drive_item(REQ_DRV_RESP, CMD_IDENTIFY, '0, 16'h0008, '0);
    drive_item(REQ_DRV_RESP, CMD_IDENTIFY, '0, 16'hFFFF, '0);
    drive_item(REQ_DRV_RESP, CMD_IDENTIFY, '0, 16'h0000, '0);

    while (step_count < 244) begin
      if (step_count % 64 == 0) begin
        in_idle = ($urandom_range(0, 3) != 0);
        out_idle = ($urandom_range(0, 3) != 0);
      end
      step_count++;
      next_step();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
